// ----- rtl/owb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the 1-wire bus master.
// No dependencies; every other file of the block imports this package.
package owb_pkg;

  // Field widths of the tick request and the result.
  localparam int CMD_W      = 2;
  localparam int DATA_W     = 8;
  localparam int LONG_W     = 10;
  localparam int SHORT_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LONG_W;

  // Commands carried by a tick request.
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_BYTE  = 2'd2,
    CMD_BIT   = 2'd3
  } cmd_t;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_RST_LOW     = 3'd1,
    PH_RST_WAIT    = 3'd2,
    PH_RST_RECOV   = 3'd3,
    PH_SLOT_LOW    = 3'd4,
    PH_SLOT_SAMPLE = 3'd5,
    PH_SLOT_HOLD   = 3'd6,
    PH_SLOT_RECOV  = 3'd7
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_SMP  = 3'd1,
    REG_RESET_RECOV   = 3'd2,
    REG_SLOT_LOW      = 3'd3,
    REG_SLOT_SAMPLE   = 3'd4,
    REG_SLOT_HOLD     = 3'd5,
    REG_SLOT_RECOV    = 3'd6
  } cfg_idx_t;

  // Reset values of the timing registers.
  localparam logic [LONG_W-1:0]  RST_RESET_LOW    = 10'd480;
  localparam logic [LONG_W-1:0]  RST_PRESENCE_SMP = 10'd70;
  localparam logic [LONG_W-1:0]  RST_RESET_RECOV  = 10'd410;
  localparam logic [SHORT_W-1:0] RST_SLOT_LOW     = 7'd1;
  localparam logic [SHORT_W-1:0] RST_SLOT_SAMPLE  = 7'd13;
  localparam logic [SHORT_W-1:0] RST_SLOT_HOLD    = 7'd45;
  localparam logic [SHORT_W-1:0] RST_SLOT_RECOV   = 7'd10;

  // Timing settings handed from the register file to the sequencer.
  typedef struct packed {
    logic [LONG_W-1:0]  reset_low_ticks;
    logic [LONG_W-1:0]  presence_sample_ticks;
    logic [LONG_W-1:0]  reset_recovery_ticks;
    logic [SHORT_W-1:0] slot_low_ticks;
    logic [SHORT_W-1:0] slot_sample_ticks;
    logic [SHORT_W-1:0] slot_hold_ticks;
    logic [SHORT_W-1:0] slot_recovery_ticks;
  } cfg_t;

  // One result of the sequencer.
  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] rx_data;
    logic              presence;
  } res_t;

endpackage

// ----- rtl/owb_in_if.sv -----
`timescale 1ns / 1ps
// Tick request channel: valid/ready handshake with command, data and line level.
// Depends on owb_pkg for the field widths.
interface owb_in_if import owb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DATA_W-1:0] tx_data;
  logic              line_level;

  modport source (output valid, command, tx_data, line_level, input ready);
  modport sink   (input valid, command, tx_data, line_level, output ready);
endinterface

// ----- rtl/owb_out_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with line drive, status and received data.
// Depends on owb_pkg for the field widths.
interface owb_out_if import owb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              drive_low;
  logic              busy_res;
  logic              done_res;
  logic [DATA_W-1:0] rx_data;
  logic              presence;

  modport source (output valid, drive_low, busy_res, done_res, rx_data, presence,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, rx_data, presence,
                  output ready);
endinterface

// ----- rtl/owb_cfg.sv -----
`timescale 1ns / 1ps
// Timing register file of the 1-wire bus master, written through a plain write port.
// Depends on owb_pkg for register indexes, reset values and the cfg_t bundle.
module owb_cfg import owb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.reset_low_ticks       <= RST_RESET_LOW;
      regs.presence_sample_ticks <= RST_PRESENCE_SMP;
      regs.reset_recovery_ticks  <= RST_RESET_RECOV;
      regs.slot_low_ticks        <= RST_SLOT_LOW;
      regs.slot_sample_ticks     <= RST_SLOT_SAMPLE;
      regs.slot_hold_ticks       <= RST_SLOT_HOLD;
      regs.slot_recovery_ticks   <= RST_SLOT_RECOV;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_RESET_LOW:    regs.reset_low_ticks       <= wr_data[LONG_W-1:0];
        REG_PRESENCE_SMP: regs.presence_sample_ticks <= wr_data[LONG_W-1:0];
        REG_RESET_RECOV:  regs.reset_recovery_ticks  <= wr_data[LONG_W-1:0];
        REG_SLOT_LOW:     regs.slot_low_ticks        <= wr_data[SHORT_W-1:0];
        REG_SLOT_SAMPLE:  regs.slot_sample_ticks     <= wr_data[SHORT_W-1:0];
        REG_SLOT_HOLD:    regs.slot_hold_ticks       <= wr_data[SHORT_W-1:0];
        REG_SLOT_RECOV:   regs.slot_recovery_ticks   <= wr_data[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- rtl/owb_seq.sv -----
`timescale 1ns / 1ps
// Phase sequencer of the 1-wire bus master: one tick of bus timing per step.
// Depends on owb_pkg for phases, commands, cfg_t and res_t.
module owb_seq import owb_pkg::*; #(
  parameter int BITS_PER_BYTE = 8,
  parameter int TIMER_WIDTH   = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CMD_W-1:0]  command,
  input  logic [DATA_W-1:0] tx_data,
  input  logic              line_level,
  input  cfg_t              cfg,
  output res_t              res
);

  localparam int BIDX_W = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
  localparam int DUR_W  = ((TIMER_WIDTH > LONG_W) ? TIMER_WIDTH : LONG_W) + 1;
  localparam logic [DUR_W-1:0]  MAX_DUR   = DUR_W'({TIMER_WIDTH{1'b1}});
  localparam logic [BIDX_W:0]   BIT_COUNT = (BIDX_W + 1)'(BITS_PER_BYTE);

  // Sequencer state.
  phase_t                   phase, phase_next;
  cmd_t                     operation, operation_next;
  logic [TIMER_WIDTH-1:0]   tick_counter, tick_counter_next;
  logic [BIDX_W-1:0]        bit_index, bit_index_next;
  logic [DATA_W-1:0]        shift_data, shift_data_next;
  logic                     presence_flag, presence_flag_next;
  logic                     slot_low_hold, slot_low_hold_next;

  // Timer helpers.
  phase_t                   ph_run;
  logic [LONG_W-1:0]        dur_sel;
  logic [DUR_W-1:0]         dur_eff;
  logic [DUR_W-1:0]         cnt_inc;
  logic [TIMER_WIDTH-1:0]   cnt_run;
  logic                     expire;
  logic                     drive;
  logic                     done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= CMD_NONE;
      tick_counter  <= '0;
      bit_index     <= '0;
      shift_data    <= '0;
      presence_flag <= 1'b0;
      slot_low_hold <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      operation     <= operation_next;
      tick_counter  <= tick_counter_next;
      bit_index     <= bit_index_next;
      shift_data    <= shift_data_next;
      presence_flag <= presence_flag_next;
      slot_low_hold <= slot_low_hold_next;
    end
  end

  // Duration of the phase this tick runs in; zero acts as one, clipped to the timer.
  always_comb begin
    unique case (ph_run)
      PH_RST_LOW:     dur_sel = cfg.reset_low_ticks;
      PH_RST_WAIT:    dur_sel = cfg.presence_sample_ticks;
      PH_RST_RECOV:   dur_sel = cfg.reset_recovery_ticks;
      PH_SLOT_LOW:    dur_sel = LONG_W'(cfg.slot_low_ticks);
      PH_SLOT_SAMPLE: dur_sel = LONG_W'(cfg.slot_sample_ticks);
      PH_SLOT_HOLD:   dur_sel = LONG_W'(cfg.slot_hold_ticks);
      PH_SLOT_RECOV:  dur_sel = LONG_W'(cfg.slot_recovery_ticks);
      default:        dur_sel = '0;
    endcase
    dur_eff = DUR_W'(dur_sel);
    if (dur_eff == '0) dur_eff = DUR_W'(1);
    if (dur_eff > MAX_DUR) dur_eff = MAX_DUR;
    cnt_inc = DUR_W'(cnt_run) + DUR_W'(1);
    expire  = (cnt_inc >= dur_eff);
  end

  // Command take, then one tick of the running phase.
  always_comb begin
    phase_next         = phase;
    operation_next     = operation;
    cnt_run            = tick_counter;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    presence_flag_next = presence_flag;
    slot_low_hold_next = slot_low_hold;
    drive              = 1'b0;
    done               = 1'b0;

    // A command starts only from idle.
    if (phase == PH_IDLE && cmd_t'(command) != CMD_NONE) begin
      operation_next = cmd_t'(command);
      cnt_run        = '0;
      bit_index_next = '0;
      if (cmd_t'(command) == CMD_RESET) begin
        phase_next = PH_RST_LOW;
      end else begin
        shift_data_next = (cmd_t'(command) == CMD_BYTE) ? tx_data
                                                        : {{(DATA_W-1){1'b0}}, tx_data[0]};
        phase_next = PH_SLOT_LOW;
      end
    end
    ph_run = phase_next;

    tick_counter_next = (ph_run == PH_IDLE) ? cnt_run
                      : (expire ? '0 : cnt_inc[TIMER_WIDTH-1:0]);

    unique case (ph_run)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive = 1'b1;
        if (expire) phase_next = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (expire) begin
          presence_flag_next = ~line_level;
          phase_next         = PH_RST_RECOV;
        end
      end
      PH_RST_RECOV: begin
        if (expire) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_SLOT_LOW: begin
        drive = 1'b1;
        if (expire) begin
          slot_low_hold_next = ~shift_data_next[0];
          phase_next         = PH_SLOT_SAMPLE;
        end
      end
      PH_SLOT_SAMPLE: begin
        drive = slot_low_hold;
        if (expire) begin
          if (operation_next == CMD_BIT) begin
            shift_data_next = {{(DATA_W-1){1'b0}}, line_level};
          end else begin
            shift_data_next = {line_level, shift_data_next[DATA_W-1:1]};
          end
          phase_next = PH_SLOT_HOLD;
        end
      end
      PH_SLOT_HOLD: begin
        drive = slot_low_hold;
        if (expire) phase_next = PH_SLOT_RECOV;
      end
      PH_SLOT_RECOV: begin
        if (expire) begin
          // The last slot of a byte, or the only slot of a bit, ends the command.
          if (operation_next != CMD_BYTE ||
              ({1'b0, bit_index_next} + (BIDX_W + 1)'(1)) >= BIT_COUNT) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            bit_index_next = bit_index_next + BIDX_W'(1);
            phase_next     = PH_SLOT_LOW;
          end
        end
      end
      default: ;
    endcase

    res.drive_low = drive;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.rx_data   = shift_data_next;
    res.presence  = presence_flag_next;
  end

  // An idle sequencer always has its tick counter cleared.
  a_idle_counter_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_counter == '0))
    else $error("tick counter not cleared while idle");

endmodule

// ----- rtl/one_wire_bus_master.sv -----
`timescale 1ns / 1ps
// 1-wire bus master top level: register file, phase sequencer and result register.
// Depends on owb_pkg, owb_in_if, owb_out_if, owb_cfg and owb_seq.
//
// Usage: each request on the ticks channel is one microsecond of bus time. It carries
// the sampled line level and may carry a command (reset/presence, byte or single bit),
// which is taken only while the master is idle. Every request produces exactly one
// result on the results channel: the line drive for that tick, busy, a done pulse,
// the shift register and the presence flag of the last reset.
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the sequencer steps
// once per request and the result register decouples the two channels.
// Stall: while a result waits on results.ready, ticks.ready stays high only if the
// result is taken in the same cycle; otherwise no request is accepted and the
// sequencer holds.
// Reset: synchronous; the sequencer returns to idle, presence and the shift register
// clear, and timing registers take their defaults. The user, not the block, must
// write timing registers via wr_en/wr_index/wr_data only while the master is idle.
module one_wire_bus_master import owb_pkg::*; #(
  parameter int BITS_PER_BYTE = 8,
  parameter int TIMER_WIDTH   = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  owb_in_if.sink                ticks,
  owb_out_if.source             results,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  cfg_t cfg;
  res_t res;
  res_t out_data;
  logic out_valid;
  logic accept;

  owb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  owb_seq #(
    .BITS_PER_BYTE (BITS_PER_BYTE),
    .TIMER_WIDTH   (TIMER_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .command    (ticks.command),
    .tx_data    (ticks.tx_data),
    .line_level (ticks.line_level),
    .cfg        (cfg),
    .res        (res)
  );

  // Request handshake: take a request when the result register is free or draining.
  assign ticks.ready = !out_valid || results.ready;
  assign accept      = ticks.valid && ticks.ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  assign results.valid     = out_valid;
  assign results.drive_low = out_data.drive_low;
  assign results.busy_res  = out_data.busy_res;
  assign results.done_res  = out_data.done_res;
  assign results.rx_data   = out_data.rx_data;
  assign results.presence  = out_data.presence;

  // Every accepted request yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // A completing operation is no longer busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done reported while still busy");

  // The bus is never pulled low while the master is idle.
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.busy_res) |-> !out_data.drive_low)
    else $error("line driven low while idle");

  // A held result is not overwritten while the receiver stalls.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule
